// ===== rtl/dq_pkg.sv =====
// Shared types, codes and constants for the double-ended queue.
`default_nettype none
package dq_pkg;

    localparam int DQ_DEPTH = 256;
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 9;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] value;
    } t_dq_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] popped_value;
        logic [1:0]              status;
        logic [OCC_W-1:0]        occupancy;
    } t_dq_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic execute;
        logic read_done;
    } t_dq_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic pop_ok;
    } t_dq_sts;

endpackage
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: controller plus datapath.
//
// Double-ended queue of signed 32-bit values held in a ring of DEPTH entries.
// Pulse start with an operation in i_item (push front, push back, pop front,
// pop back) while busy is low; the transfer is taken at that edge. Every
// operation returns exactly one result on o_result, marked by o_done for a
// single cycle; the receiver cannot hold results off, so capture it then.
// A push or a refused operation passes through accept and execute; a
// successful pop adds a read step, because the entry store is a RAM with
// a registered read port and the read data arrives in the cycle after the
// address. busy stays high from the accept until the result is loaded, so
// a new item can be accepted in the same cycle o_done is shown.
// A pop on an empty queue returns -1 with status empty; a push on a full
// queue drops the value and returns status full. occupancy is the count
// after the operation, reported in 9 bits. The store needs no clearing:
// a pop only ever reads slots that an earlier push wrote.
`default_nettype none
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire dq_pkg::t_dq_in  i_item,
    output logic                 o_done,
    output dq_pkg::t_dq_out      o_result
);
    import dq_pkg::*;

    t_dq_cmd cmd;
    t_dq_sts sts;

    // Sequence each transfer: accept, execute, and read when a pop hits data.
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold pointers, count and the entry store; advance them on execute.
    dq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
// Sequencer for the double-ended queue: accept, execute, optional read.
`default_nettype none
module dq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dq_pkg::t_dq_sts  i_sts,
    output dq_pkg::t_dq_cmd       o_cmd
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.pop_ok ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cmd.capture   = (r_state == S_IDLE) && start;
    assign o_cmd.execute   = (r_state == S_EXEC);
    assign o_cmd.read_done = (r_state == S_READ);

    a_read_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_EXEC))
        else $error("read step entered without an execute step");

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("accepted transfer not executed");

endmodule
`default_nettype wire

// ===== rtl/dq_dp.sv =====
// Datapath: entry store, front/back pointers, count and result register.
`default_nettype none
module dq_dp #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dq_pkg::t_dq_in  i_item,
    input  wire dq_pkg::t_dq_cmd i_cmd,
    output dq_pkg::t_dq_sts      o_sts,
    output logic                 o_done,
    output dq_pkg::t_dq_out      o_result
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [1:0]        r_mode;
    logic [VAL_W-1:0]  r_value;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [PTR_W-1:0]  r_back,  n_back;
    logic [CNT_W-1:0]  r_count, n_count;
    t_dq_out           r_res,   n_res;
    logic              r_done;

    logic              is_push, is_full, is_empty;
    logic              we;
    logic [PTR_W-1:0]  waddr, raddr;
    logic [PTR_W-1:0]  front_prev, front_next, back_prev, back_next;
    logic [VAL_W-1:0]  rdata;

    assign front_prev = (r_front == '0)   ? LAST : r_front - 1'b1;
    assign front_next = (r_front == LAST) ? '0   : r_front + 1'b1;
    assign back_prev  = (r_back == '0)    ? LAST : r_back - 1'b1;
    assign back_next  = (r_back == LAST)  ? '0   : r_back + 1'b1;

    assign is_push  = (r_mode == MODE_PUSH_FRONT) || (r_mode == MODE_PUSH_BACK);
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    assign o_sts.pop_ok = !is_push && !is_empty;

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        n_res   = r_res;
        we      = 1'b0;
        waddr   = r_back;
        raddr   = r_front;
        if (i_cmd.execute) begin
            if (is_push) begin
                n_res.popped_value = '0;
                if (is_full) begin
                    n_res.status    = ST_FULL;
                    n_res.occupancy = OCC_W'(r_count);
                end else begin
                    we = 1'b1;
                    if (r_mode == MODE_PUSH_FRONT) begin
                        waddr   = front_prev;
                        n_front = front_prev;
                    end else begin
                        waddr  = r_back;
                        n_back = back_next;
                    end
                    n_count         = r_count + 1'b1;
                    n_res.status    = ST_OK;
                    n_res.occupancy = OCC_W'(n_count);
                end
            end else if (is_empty) begin
                n_res.popped_value = '1;
                n_res.status       = ST_EMPTY;
                n_res.occupancy    = OCC_W'(r_count);
            end else begin
                // Issue the read now; data lands in the read step.
                if (r_mode == MODE_POP_FRONT) begin
                    raddr   = r_front;
                    n_front = front_next;
                end else begin
                    raddr  = back_prev;
                    n_back = back_prev;
                end
                n_count = r_count - 1'b1;
            end
        end else if (i_cmd.read_done) begin
            n_res.popped_value = rdata;
            n_res.status       = ST_OK;
            n_res.occupancy    = OCC_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_done  <= (i_cmd.execute && !o_sts.pop_ok) || i_cmd.read_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_item.mode;
            r_value <= i_item.value;
        end
        r_res <= n_res;
    end

    dq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_done   = r_done;
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && !is_push && !is_empty |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not drop the count by one");

endmodule
`default_nettype wire

// ===== dv/dq_checker.sv =====
// Scoreboard for the double-ended queue: mirrors the ring and checks every result.
`default_nettype none
module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_busy,
    input  wire t_dq_in  i_item,
    input  wire logic    i_done,
    input  wire t_dq_out i_result,
    output int           o_mismatch_count,
    output int           o_pending
);

    logic [VAL_W-1:0] ring [DEPTH];
    int unsigned      head_slot;
    int unsigned      tail_slot;
    int unsigned      held;
    t_dq_out          expected_q [$];

    // Apply one operation to the mirrored ring and return what the block must answer.
    function automatic t_dq_out apply_op(input t_dq_in op);
        t_dq_out ans;
        ans.popped_value = '0;
        ans.status       = ST_OK;
        case (op.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    ans.status = ST_FULL;
                end else if (op.mode == MODE_PUSH_FRONT) begin
                    head_slot       = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                    ring[head_slot] = op.value;
                    held++;
                end else begin
                    ring[tail_slot] = op.value;
                    tail_slot       = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    ans.status       = ST_EMPTY;
                    ans.popped_value = '1;
                end else if (op.mode == MODE_POP_FRONT) begin
                    ans.popped_value = ring[head_slot];
                    head_slot        = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
                    held--;
                end else begin
                    tail_slot        = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                    ans.popped_value = ring[tail_slot];
                    held--;
                end
            end
        endcase
        ans.occupancy = OCC_W'(held);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input t_dq_out want,
                                   input t_dq_out got);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display("%s: expected value %0d status %0d occupancy %0d, got value %0d status %0d occupancy %0d",
                     what, want.popped_value, want.status, want.occupancy,
                     got.popped_value, got.status, got.occupancy);
    endtask

    // Check results before queueing new ones: a result never belongs to the
    // transfer taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot = 0;
            tail_slot = 0;
            held      = 0;
            expected_q.delete();
        end else begin
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_result);
                end else begin
                    t_dq_out want;
                    want = expected_q.pop_front();
                    if (i_result.popped_value !== want.popped_value ||
                        i_result.status !== want.status ||
                        i_result.occupancy !== want.occupancy)
                        report_mismatch("result mismatch", want, i_result);
                end
            end
            if (i_start && i_busy == 1'b0)
                expected_q.push_back(apply_op(i_item));
        end
        o_pending = expected_q.size();
    end

endmodule
`default_nettype wire

// ===== dv/tb_double_ended_queue.sv =====
// Testbench top for the double-ended queue: stimulus, watchdog and verdict.
`default_nettype none
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 8;     // covers the slowest answer, a successful pop
    localparam int MIX_OPS        = 45;    // random operations per idling phase
    localparam int EDGE_OPS       = 20;    // mixed operations around the full boundary
    localparam int UNWIND_OPS     = 64;    // pops after the full boundary work

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_dq_in  item    = '0;
    logic    busy;
    logic    done;
    t_dq_out result;

    int mismatch_count;
    int pending;
    int idle_cycles;
    int sender_idle_pct;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    double_ended_queue i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_done   (done),
        .o_result (result)
    );

    // The checker sits beside the block, sees both channels and keeps the
    // expected answers; the top only drives and judges.
    dq_checker #(
        .DEPTH (DQ_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_item           (item),
        .i_done           (done),
        .i_result         (result),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // Bias values toward the sign, all-ones and zero extremes, otherwise take any
    // 32-bit pattern so every bit toggles.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Choose either end with equal odds; push_pct steers occupancy up or down.
    function automatic logic [1:0] pick_mode(input int push_pct);
        logic at_back;
        at_back = 1'($urandom);
        if ($urandom_range(99) < push_pct)
            return at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return at_back ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    // Offer one operation and hold it until the block takes it. Idle first at
    // the current sender rate; start stays high between back-to-back transfers.
    task automatic send_op(input logic [1:0] op_mode, input logic [VAL_W-1:0] op_value);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        item  <= '{mode: op_mode, value: op_value};
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_mix(input int count, input int push_pct);
        for (int n = 0; n < count; n++)
            send_op(pick_mode(push_pct), pick_value());
    endtask

    // Drop start and hold off until every outstanding result has come back.
    // Step one edge first so the last transfer is already counted.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((start && busy == 1'b0) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sender_idle_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pops on an empty queue at both ends, a push at the front
        // right after reset so the front pointer wraps below slot zero, value
        // extremes at both ends, then unwind from both ends back to empty.
        send_op(MODE_POP_FRONT,  pick_value());
        send_op(MODE_POP_BACK,   pick_value());
        send_op(MODE_PUSH_FRONT, 32'h8000_0000);
        send_op(MODE_PUSH_BACK,  32'h7FFF_FFFF);
        send_op(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(MODE_PUSH_BACK,  32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'h5555_5555);
        send_op(MODE_PUSH_BACK,  32'hAAAA_AAAA);
        send_op(MODE_POP_BACK,   pick_value());
        send_op(MODE_POP_FRONT,  pick_value());
        send_op(MODE_POP_BACK,   pick_value());
        send_op(MODE_POP_FRONT,  pick_value());
        send_op(MODE_POP_FRONT,  pick_value());
        send_op(MODE_POP_BACK,   pick_value());
        send_op(MODE_POP_BACK,   pick_value());
        send_op(MODE_POP_FRONT,  pick_value());
        // Push at one end, pop at the other, across the wrapped pointers.
        send_op(MODE_PUSH_BACK,  32'h0000_0001);
        send_op(MODE_POP_FRONT,  pick_value());
        send_op(MODE_PUSH_FRONT, 32'h0000_0002);
        send_op(MODE_POP_BACK,   pick_value());
        wait_drained();

        // Random phases: no idling, heavy sender idling, light sender idling.
        // The last phase also fills the ring to full, pushes past it, works
        // the full boundary, then pops part of the way back down.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 74;
                default: sender_idle_pct = 16;
            endcase
            send_mix(MIX_OPS, 55);
            if (phase == 2) begin
                send_mix(DQ_DEPTH + 3, 100);
                send_mix(EDGE_OPS, 50);
                send_mix(UNWIND_OPS, 0);
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/dq_dp.sv
rtl/double_ended_queue.sv
dv/dq_checker.sv
dv/tb_double_ended_queue.sv
